FILE: rtl/core/pva_pkg.sv
// shared types and constants of the polyphonic voice allocator
package pva_pkg;

  // payload field widths
  localparam int unsigned ACTIVE_W = 4;
  localparam int unsigned SLOT_W   = 2;
  localparam int unsigned PITCH_W  = 16;
  localparam int unsigned VEL_W    = 16;
  localparam int unsigned INDEX_W  = 2;
  localparam int unsigned MASK_W   = 4;
  localparam int unsigned AGE_W    = 32;

  // request operation codes
  typedef enum logic {
    OP_TRIGGER = 1'b0,
    OP_DEMOTE  = 1'b1
  } pva_op_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FREE,
    ST_OLD,
    ST_COMMIT
  } pva_state_e;

  // control from the sequencer to the steal unit
  typedef struct packed {
    logic clear;
    logic step;
  } pva_scan_ctl_t;

endpackage

FILE: rtl/core/pva_if.sv
// request and response channel interfaces of the voice allocator
interface pva_req_if;
  logic                             valid;
  logic                             ready;
  pva_pkg::pva_op_e                 opcode;
  logic [pva_pkg::ACTIVE_W-1:0]     active_mask;
  logic                             sustain_mode;
  logic [pva_pkg::SLOT_W-1:0]       note_slot;
  logic [pva_pkg::PITCH_W-1:0]      pitch_code;
  logic [pva_pkg::VEL_W-1:0]        velocity;

  modport source (
    output valid, opcode, active_mask, sustain_mode, note_slot, pitch_code, velocity,
    input  ready
  );
  modport sink (
    input  valid, opcode, active_mask, sustain_mode, note_slot, pitch_code, velocity,
    output ready
  );
endinterface

interface pva_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [pva_pkg::INDEX_W-1:0]      voice_index;
  logic                             was_stolen;
  logic                             voice_sustains;
  logic [pva_pkg::MASK_W-1:0]       demoted_mask;
  logic [pva_pkg::PITCH_W-1:0]      note_pitch;
  logic [pva_pkg::VEL_W-1:0]        note_velocity;

  modport source (
    output valid, voice_index, was_stolen, voice_sustains, demoted_mask, note_pitch,
           note_velocity,
    input  ready
  );
  modport sink (
    input  valid, voice_index, was_stolen, voice_sustains, demoted_mask, note_pitch,
           note_velocity,
    output ready
  );
endinterface

FILE: rtl/core/pva_steal_unit.sv
// oldest-voice tracker with one shared age comparator, one voice per step
module pva_steal_unit #(
  parameter int unsigned VOICE_COUNT = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pva_pkg::pva_scan_ctl_t                 ctl_i,
  input  logic [((VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1)-1:0] voice_i,
  input  logic [pva_pkg::AGE_W-1:0]              age_i,
  input  logic                                   sustain_i,
  output logic [((VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1)-1:0] pick_o
);

  localparam int unsigned VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  logic                      have_free_q, have_sus_q;
  logic [pva_pkg::AGE_W-1:0] old_free_q, old_sus_q;
  logic [VW-1:0]             open_sel_q, held_sel_q;
  logic [pva_pkg::AGE_W-1:0] ref_age;
  logic                      have_ref;
  logic                      take;

  // the one comparator, shared by both candidate classes
  always_comb begin
    ref_age  = sustain_i ? old_sus_q : old_free_q;
    have_ref = sustain_i ? have_sus_q : have_free_q;
    take     = !have_ref || (age_i < ref_age);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_free_q <= 1'b0;
      have_sus_q  <= 1'b0;
    end else if (ctl_i.clear) begin
      have_free_q <= 1'b0;
      have_sus_q  <= 1'b0;
    end else if (ctl_i.step && take) begin
      if (sustain_i) begin
        have_sus_q <= 1'b1;
      end else begin
        have_free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step && take) begin
      if (sustain_i) begin
        old_sus_q  <= age_i;
        held_sel_q <= voice_i;
      end else begin
        old_free_q <= age_i;
        open_sel_q <= voice_i;
      end
    end
  end

  // non-sustaining voices first, sustaining ones only as fallback
  assign pick_o = have_free_q ? open_sel_q : held_sel_q;

endmodule

FILE: rtl/core/polyphonic_voice_allocator.sv
// top level of the polyphonic voice allocator
//
// Each request either triggers a note or demotes all sustaining voices, and
// gives exactly one response. A trigger walks the voices one per cycle,
// starting at the rotating pointer, and takes the first one whose active bit
// is clear; when every voice sounds, a second pass walks the voices in index
// order through a single shared 32-bit age comparator and steals the oldest
// non-sustaining voice (oldest sustaining one if all sustain, ties to the
// lowest index). A demote goes from accept straight to the commit state, a
// trigger first walks the voices for a free one, and a steal adds the age
// pass before its commit; a request is accepted only in the idle state, so
// the next one waits until the commit of the last one is done.
// The response sits in an output register, so a new request is taken while
// a finished response still waits; only the final commit cycle waits for
// that register to drain. Voices at index 4 and up have no active bit and
// always count as free, and they never appear in demoted_mask. Pitch and
// velocity pass through unchanged; voice_index keeps its low two bits.
module polyphonic_voice_allocator #(
  parameter int unsigned VOICE_COUNT = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pva_req_if.sink    req_i,
  pva_rsp_if.source  rsp_o
);

  localparam int unsigned VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [VW-1:0] LAST = VW'(VOICE_COUNT - 1);

  // sequencer
  pva_pkg::pva_state_e state_q, state_d;

  // latched request
  pva_pkg::pva_op_e              op_q;
  logic [VOICE_COUNT-1:0]        active_q;
  logic                          sus_q;
  logic                          slot0_q;
  logic [pva_pkg::PITCH_W-1:0]   pitch_q;
  logic [pva_pkg::VEL_W-1:0]     vel_q;

  // scan bookkeeping
  logic [VW-1:0] cand_q, cand_d;
  logic [VW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] pick_q, pick_d;
  logic          stolen_q, stolen_d;
  logic [VW-1:0] cand_nx;

  // allocator state
  logic [VW-1:0]             ptr_q;
  logic [pva_pkg::AGE_W-1:0] seq_q;
  logic [pva_pkg::AGE_W-1:0] age_q [VOICE_COUNT];
  logic [VOICE_COUNT-1:0]    marks_q;

  // response register
  logic                          out_valid_q;
  logic [pva_pkg::INDEX_W-1:0]   out_index_q;
  logic                          out_stolen_q;
  logic                          out_sus_q;
  logic [pva_pkg::MASK_W-1:0]    out_demoted_q;
  logic [pva_pkg::PITCH_W-1:0]   out_pitch_q;
  logic [pva_pkg::VEL_W-1:0]     out_vel_q;

  // handshake and datapath controls
  logic                   load;
  logic                   commit;
  pva_pkg::pva_scan_ctl_t scan_ctl;
  logic [VW-1:0]          steal_pick;
  logic [VW-1:0]          pick_fin;
  logic [VOICE_COUNT-1:0] marks_new;
  logic [VOICE_COUNT-1:0] demoted;
  logic [pva_pkg::AGE_W-1:0] seq_nx;

  // wrapping walk over the voices
  assign cand_nx = (cand_q == LAST) ? '0 : cand_q + VW'(1);

  pva_steal_unit #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_steal (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .voice_i   (cand_q),
    .age_i     (age_q[cand_q]),
    .sustain_i (marks_q[cand_q]),
    .pick_o    (steal_pick)
  );

  // next state and controls
  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    load        = 1'b0;
    commit      = 1'b0;
    scan_ctl    = '0;
    cand_d      = cand_q;
    cnt_d       = cnt_q;
    pick_d      = pick_q;
    stolen_d    = stolen_q;
    case (state_q)
      pva_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          load     = 1'b1;
          stolen_d = 1'b0;
          cand_d   = ptr_q;
          cnt_d    = '0;
          if (req_i.opcode == pva_pkg::OP_DEMOTE) begin
            state_d = pva_pkg::ST_COMMIT;
          end else begin
            state_d = pva_pkg::ST_FREE;
          end
        end
      end
      pva_pkg::ST_FREE: begin
        // probe one voice per cycle from the rotating pointer
        if (!active_q[cand_q]) begin
          pick_d  = cand_q;
          state_d = pva_pkg::ST_COMMIT;
        end else if (cnt_q == LAST) begin
          // everything sounds: restart at voice 0 for the age pass
          cand_d         = '0;
          stolen_d       = 1'b1;
          scan_ctl.clear = 1'b1;
          state_d        = pva_pkg::ST_OLD;
        end else begin
          cand_d = cand_nx;
          cnt_d  = cnt_q + VW'(1);
        end
      end
      pva_pkg::ST_OLD: begin
        // one age compare per cycle in index order
        scan_ctl.step = 1'b1;
        if (cand_q == LAST) begin
          state_d = pva_pkg::ST_COMMIT;
        end else begin
          cand_d = cand_nx;
        end
      end
      pva_pkg::ST_COMMIT: begin
        // update state and load the response once the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          commit  = 1'b1;
          state_d = pva_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pva_pkg::ST_IDLE;
      end
    endcase
  end

  // chosen voice, new sustain marks and the ones that got cleared
  always_comb begin
    pick_fin = stolen_q ? steal_pick : pick_q;
    seq_nx   = seq_q + pva_pkg::AGE_W'(1);
    if (op_q == pva_pkg::OP_DEMOTE) begin
      marks_new = '0;
    end else begin
      marks_new           = (sus_q && slot0_q) ? '0 : marks_q;
      marks_new[pick_fin] = sus_q;
    end
    demoted = marks_q & ~marks_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pva_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // scan registers and allocator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q   <= '0;
      cnt_q    <= '0;
      pick_q   <= '0;
      stolen_q <= 1'b0;
      ptr_q    <= '0;
      seq_q    <= '0;
      marks_q  <= '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        age_q[v] <= '0;
      end
    end else begin
      cand_q   <= cand_d;
      cnt_q    <= cnt_d;
      pick_q   <= pick_d;
      stolen_q <= stolen_d;
      if (commit) begin
        marks_q <= marks_new;
        if (op_q == pva_pkg::OP_TRIGGER) begin
          ptr_q           <= (pick_fin == LAST) ? '0 : pick_fin + VW'(1);
          seq_q           <= seq_nx;
          age_q[pick_fin] <= seq_nx;
        end
      end
    end
  end

  // latched request fields
  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q     <= req_i.opcode;
      active_q <= VOICE_COUNT'(req_i.active_mask);
      sus_q    <= req_i.sustain_mode;
      slot0_q  <= (req_i.note_slot == '0);
      pitch_q  <= req_i.pitch_code;
      vel_q    <= req_i.velocity;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_demoted_q <= pva_pkg::MASK_W'(demoted);
      if (op_q == pva_pkg::OP_DEMOTE) begin
        // demote responses carry only the cleared mask
        out_index_q  <= '0;
        out_stolen_q <= 1'b0;
        out_sus_q    <= 1'b0;
        out_pitch_q  <= '0;
        out_vel_q    <= '0;
      end else begin
        out_index_q  <= pva_pkg::INDEX_W'(pick_fin);
        out_stolen_q <= stolen_q;
        out_sus_q    <= sus_q;
        out_pitch_q  <= pitch_q;
        out_vel_q    <= vel_q;
      end
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.voice_index    = out_index_q;
  assign rsp_o.was_stolen     = out_stolen_q;
  assign rsp_o.voice_sustains = out_sus_q;
  assign rsp_o.demoted_mask   = out_demoted_q;
  assign rsp_o.note_pitch     = out_pitch_q;
  assign rsp_o.note_velocity  = out_vel_q;

endmodule

FILE: tb/pva_tb_pkg.sv
// request and response records plus the allocation scoreboard for the voice allocator bench
`timescale 1ns / 1ps

package pva_tb_pkg;

  localparam int unsigned VOICES    = 4;
  localparam int unsigned SLOTS     = 4;
  localparam logic [2:0]  SLOT_NONE = 3'd7;

  typedef struct packed {
    pva_pkg::pva_op_e              op;
    logic [pva_pkg::ACTIVE_W-1:0]  active;
    logic                          sustain;
    logic [pva_pkg::SLOT_W-1:0]    slot;
    logic [pva_pkg::PITCH_W-1:0]   pitch;
    logic [pva_pkg::VEL_W-1:0]     vel;
  } voice_req_t;

  typedef struct packed {
    logic [pva_pkg::INDEX_W-1:0]   voice_index;
    logic                          stolen;
    logic                          sustains;
    logic [pva_pkg::MASK_W-1:0]    demoted;
    logic [pva_pkg::PITCH_W-1:0]   pitch;
    logic [pva_pkg::VEL_W-1:0]     vel;
  } voice_rsp_t;

  class voice_scoreboard;
    logic [1:0]                 rotor;
    logic [pva_pkg::AGE_W-1:0]  trig_seq;
    logic [pva_pkg::AGE_W-1:0]  age [VOICES];
    logic [VOICES-1:0]          sustaining;
    logic [2:0]                 slot_of [VOICES];
    voice_rsp_t                 expected_notes[$];
    int unsigned                errors;

    function new();
      rotor      = '0;
      trig_seq   = '0;
      sustaining = '0;
      errors     = 0;
      for (int v = 0; v < VOICES; v++) begin
        age[v]     = '0;
        slot_of[v] = SLOT_NONE;
      end
    endfunction

    function void clear_marks();
      for (int v = 0; v < VOICES; v++) begin
        if (sustaining[v]) begin
          sustaining[v] = 1'b0;
          slot_of[v]    = SLOT_NONE;
        end
      end
    endfunction

    // picks the voice for one request and updates the allocation state
    function voice_rsp_t allocate(voice_req_t r);
      voice_rsp_t                 res;
      logic [VOICES-1:0]          marks_before;
      int                         pick;
      int                         v;
      bit                         found;
      bit                         have_free;
      bit                         have_sus;
      int                         open_sel;
      int                         held_sel;
      logic [pva_pkg::AGE_W-1:0]  open_age;
      logic [pva_pkg::AGE_W-1:0]  held_age;
      res          = '0;
      marks_before = sustaining;
      if (r.op == pva_pkg::OP_DEMOTE) begin
        clear_marks();
        res.demoted = marks_before & ~sustaining;
        return res;
      end
      pick  = 0;
      found = 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        v = (int'(rotor) + i) % VOICES;
        if (!found && !r.active[v]) begin
          pick  = v;
          found = 1'b1;
        end
      end
      if (!found) begin
        have_free = 1'b0;
        have_sus  = 1'b0;
        open_sel  = 0;
        held_sel  = 0;
        open_age  = '0;
        held_age  = '0;
        for (int w = 0; w < VOICES; w++) begin
          if (sustaining[w]) begin
            if (!have_sus || age[w] < held_age) begin
              held_age = age[w];
              held_sel = w;
              have_sus = 1'b1;
            end
          end else if (!have_free || age[w] < open_age) begin
            open_age  = age[w];
            open_sel  = w;
            have_free = 1'b1;
          end
        end
        pick = have_free ? open_sel : held_sel;
      end
      rotor     = 2'((pick + 1) % VOICES);
      trig_seq  = trig_seq + 1;
      age[pick] = trig_seq;
      if (r.sustain) begin
        if (r.slot == '0) clear_marks();
        sustaining[pick] = 1'b1;
        slot_of[pick]    = (r.slot > SLOTS - 1) ? 3'(SLOTS - 1) : 3'(r.slot);
      end else begin
        sustaining[pick] = 1'b0;
        slot_of[pick]    = SLOT_NONE;
      end
      res.voice_index = pick[pva_pkg::INDEX_W-1:0];
      res.stolen      = !found;
      res.sustains    = r.sustain;
      res.demoted     = marks_before & ~sustaining;
      res.pitch       = r.pitch;
      res.vel         = r.vel;
      return res;
    endfunction

    function void note_request(voice_req_t r);
      expected_notes.push_back(allocate(r));
    endfunction

    function int unsigned outstanding();
      return expected_notes.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check_response(voice_rsp_t got);
      voice_rsp_t want;
      if (expected_notes.size() == 0) begin
        report("unexpected response", 32'(got), 32'h0);
      end else begin
        want = expected_notes.pop_front();
        if (got.voice_index !== want.voice_index)
          report("voice_index", 32'(got.voice_index), 32'(want.voice_index));
        if (got.stolen !== want.stolen)
          report("was_stolen", 32'(got.stolen), 32'(want.stolen));
        if (got.sustains !== want.sustains)
          report("voice_sustains", 32'(got.sustains), 32'(want.sustains));
        if (got.demoted !== want.demoted)
          report("demoted_mask", 32'(got.demoted), 32'(want.demoted));
        if (got.pitch !== want.pitch)
          report("note_pitch", 32'(got.pitch), 32'(want.pitch));
        if (got.vel !== want.vel)
          report("note_velocity", 32'(got.vel), 32'(want.vel));
      end
    endtask
  endclass

endpackage

FILE: tb/tb.sv
// top-level bench for the polyphonic voice allocator
`timescale 1ns / 1ps

module tb;

  // run shape: directed requests, then three random phases, each ending in a drain
  localparam int unsigned PHASE_ITEMS  = 650;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned SETTLE       = 20;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  logic clk_i = 1'b0;
  logic rst_ni;

  pva_req_if req_if ();
  pva_rsp_if rsp_if ();

  polyphonic_voice_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  pva_tb_pkg::voice_scoreboard sb;

  // idle percentages per side, changed by the main sequence between phases
  int unsigned req_idle_pct;
  int unsigned rsp_idle_pct;
  // asks the response side for one long hold-off
  bit          long_stall_req;
  int unsigned cycles = 0;

  always #5 clk_i = ~clk_i;

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // response side: random back-pressure plus one long hold-off counted here
  initial begin : rsp_side
    int unsigned held;
    held         = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_stall_req && held < STALL_CYCLES) begin
        rsp_if.ready <= 1'b0;
        held++;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  // responses are sampled at the edge where the handshake completes
  always @(posedge clk_i) begin : rsp_monitor
    pva_tb_pkg::voice_rsp_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.voice_index = rsp_if.voice_index;
      got.stolen      = rsp_if.was_stolen;
      got.sustains    = rsp_if.voice_sustains;
      got.demoted     = rsp_if.demoted_mask;
      got.pitch       = rsp_if.note_pitch;
      got.vel         = rsp_if.note_velocity;
      sb.check_response(got);
    end
  end

  function automatic pva_tb_pkg::voice_req_t mk(pva_pkg::pva_op_e op, logic [3:0] active,
                                                logic sus, logic [1:0] slot,
                                                logic [15:0] pitch, logic [15:0] vel);
    pva_tb_pkg::voice_req_t r;
    r.op      = op;
    r.active  = active;
    r.sustain = sus;
    r.slot    = slot;
    r.pitch   = pitch;
    r.vel     = vel;
    return r;
  endfunction

  // random request: steals are common, sustain chords build up, few demotes
  function automatic pva_tb_pkg::voice_req_t random_request();
    pva_tb_pkg::voice_req_t r;
    r.op      = ($urandom_range(99) < 10) ? pva_pkg::OP_DEMOTE : pva_pkg::OP_TRIGGER;
    r.active  = ($urandom_range(99) < 45) ? 4'hF : 4'($urandom_range(15));
    r.sustain = 1'($urandom_range(1));
    r.slot    = ($urandom_range(99) < 30) ? 2'd0 : 2'($urandom_range(3));
    r.pitch   = 16'($urandom);
    r.vel     = 16'($urandom);
    return r;
  endfunction

  // offers one request, idling first at the current rate, and waits for accept
  task automatic send_request(pva_tb_pkg::voice_req_t r);
    while ($urandom_range(99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.opcode       <= r.op;
    req_if.active_mask  <= r.active;
    req_if.sustain_mode <= r.sustain;
    req_if.note_slot    <= r.slot;
    req_if.pitch_code   <= r.pitch;
    req_if.velocity     <= r.vel;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
  endtask

  // holds the request side quiet until every response is back
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin : main_seq
    pva_tb_pkg::voice_req_t directed [$];
    sb             = new();
    long_stall_req = 1'b0;
    req_idle_pct   = 34;
    rsp_idle_pct   = 71;
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.opcode       <= pva_pkg::OP_TRIGGER;
    req_if.active_mask  <= '0;
    req_if.sustain_mode <= 1'b0;
    req_if.note_slot    <= '0;
    req_if.pitch_code   <= '0;
    req_if.velocity     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all voices sounding right after reset: every age ties, lowest index wins
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'hF, 1'b0, 2'd0, 16'h0000, 16'h0000));
    // nothing sounding: round-robin from the pointer, field maxima pass through
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'h0, 1'b0, 2'd3, 16'hFFFF, 16'hFFFF));
    // fill every voice with sustaining notes, then steal among sustaining ones
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'hF, 1'b1, 2'd1, 16'h8000, 16'h0001));
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'hF, 1'b1, 2'd2, 16'h0001, 16'h8000));
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'hF, 1'b1, 2'd3, 16'h5555, 16'hAAAA));
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'hF, 1'b1, 2'd1, 16'hAAAA, 16'h5555));
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'hF, 1'b1, 2'd2, 16'h1234, 16'hFEDC));
    // non-sustain note onto a sustaining voice drops its mark
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'hF, 1'b0, 2'd0, 16'h00FF, 16'hFF00));
    // demote with marks present, then with none left
    directed.push_back(mk(pva_pkg::OP_DEMOTE, 4'hF, 1'b1, 2'd3, 16'hFFFF, 16'hFFFF));
    directed.push_back(mk(pva_pkg::OP_DEMOTE, 4'h0, 1'b0, 2'd0, 16'h0000, 16'h0000));
    // slot 0 in sustain mode clears the surface; re-marked voice stays off the mask
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'h0, 1'b1, 2'd1, 16'h0F0F, 16'hF0F0));
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'h0, 1'b1, 2'd2, 16'h3333, 16'hCCCC));
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'hF, 1'b1, 2'd0, 16'hCCCC, 16'h3333));
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'hF, 1'b1, 2'd0, 16'h7FFF, 16'h7FFF));
    // one voice busy or one voice free, each position
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'h1, 1'b0, 2'd0, 16'h0001, 16'h0002));
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'h2, 1'b0, 2'd0, 16'h0004, 16'h0008));
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'h4, 1'b1, 2'd3, 16'h0010, 16'h0020));
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'h8, 1'b1, 2'd3, 16'h0040, 16'h0080));
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'hE, 1'b0, 2'd2, 16'h0100, 16'h0200));
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'hD, 1'b1, 2'd1, 16'h0400, 16'h0800));
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'hB, 1'b0, 2'd1, 16'h1000, 16'h2000));
    directed.push_back(mk(pva_pkg::OP_TRIGGER, 4'h7, 1'b1, 2'd2, 16'h4000, 16'h8000));
    foreach (directed[i]) send_request(directed[i]);

    // phase 0: slow sender, slow receiver with one long hold-off
    // phase 1: rates swapped; phase 2: no idling at all
    for (int phase = 0; phase < 3; phase++) begin
      req_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 71 : 0;
      rsp_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 34 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 100) long_stall_req = 1'b1;
        send_request(random_request());
      end
      // sender pauses until the block has answered everything
      drain();
    end

    // allow for a stray late response before the verdict
    repeat (SETTLE) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
